>>> hw/rtl/scd_pkg.sv
// Shared constants, types and the sine table generator for the stereo chorus delay mixer.
package scd_pkg;

   // Default sizes
   localparam int HISTORY_DEPTH_DEF    = 4096;
   localparam int SAMPLE_BITS_DEF      = 16;
   localparam int SINE_TABLE_DEPTH_DEF = 1024;

   // Register field widths
   localparam int BASE_W   = 20;
   localparam int DEPTH_W  = 20;
   localparam int PERIOD_W = 20;
   localparam int DW_W     = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // Register reset values
   localparam logic [BASE_W-1:0]   BASE_RST   = 20'd307200;
   localparam logic [DEPTH_W-1:0]  DEPTH_RST  = 20'd12288;
   localparam logic [PERIOD_W-1:0] PERIOD_RST = 20'd96000;
   localparam logic [DW_W-1:0]     DW_RST     = 17'd52429;
   localparam logic [DW_W-1:0]     DW_ONE     = 17'd65536;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRYWET = 2'd3;

   // Sine table: Q1.15 magnitudes, 16 bits hold 0 .. 32768
   localparam int    SINE_MAG_W  = 16;
   localparam int    FRAC_W      = 8;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // Per-lane sequencing controls
   typedef struct packed {
      logic load_interp;
      logic load_mix;
      logic step;
      logic mbit;
   } scd_lane_ctl_type;

   // Quarter-wave sine value in Q15 from an angle in Q30
   function automatic logic [SINE_MAG_W-1:0] sine_q15_of(input longint x);
      longint x2;
      longint term;
      longint sum;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >>> 30) / 6;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 20;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 42;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 72;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 110;
      sum  = sum - term;
      if (sum < 0) sum = 0;
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 32768) sum = 32768;
      return SINE_MAG_W'(sum);
   endfunction

endpackage

>>> hw/rtl/scd_lane.sv
// One channel lane: bit-serial tap interpolation and dry/wet mix with saturation.
module scd_lane #(
   parameter int SAMPLE_BITS = scd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  scd_pkg::scd_lane_ctl_type     ctl,
   input  logic signed [SAMPLE_BITS-1:0] dry,
   input  logic signed [SAMPLE_BITS-1:0] tap_a,
   input  logic signed [SAMPLE_BITS-1:0] tap_b,
   output logic signed [SAMPLE_BITS-1:0] result
);
   import scd_pkg::*;

   localparam int MW = SAMPLE_BITS + 27;
   localparam int VW = MW - 25;
   localparam logic signed [VW-1:0] SAT_HI = VW'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1);
   localparam logic signed [VW-1:0] SAT_LO = VW'(-(64'sd1 <<< (SAMPLE_BITS-1)));

   logic signed [MW-1:0] mcand_ff, mcand_in;
   logic signed [MW-1:0] acc_ff, acc_in;
   logic signed [VW-1:0] mix_v;
   logic signed [MW-1:0] rounded;

   // Load operands, or add one partial product per cycle while step is set
   always_comb begin
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      if (ctl.load_interp) begin
         mcand_in = MW'(signed'({tap_b[SAMPLE_BITS-1], tap_b}) -
                        signed'({tap_a[SAMPLE_BITS-1], tap_a}));
         acc_in   = MW'(tap_a) <<< FRAC_W;
      end else if (ctl.load_mix) begin
         mcand_in = acc_ff - (MW'(dry) <<< FRAC_W);
         acc_in   = '0;
      end else if (ctl.step) begin
         if (ctl.mbit) acc_in = acc_ff + mcand_ff;
         mcand_in = mcand_ff <<< 1;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
   end

   // Round half up, add the dry sample, saturate
   always_comb begin
      rounded = (acc_ff + (MW'(1) <<< 24)) >>> 25;
      mix_v   = VW'(rounded) + VW'(dry);
      if (mix_v > SAT_HI)
         result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      else if (mix_v < SAT_LO)
         result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      else
         result = SAMPLE_BITS'(mix_v);
   end

endmodule

>>> hw/rtl/stereo_chorus_delay_mixer.sv
// Stereo chorus: sine-modulated delay lines, interpolation and dry/wet mix.
// From input transfer to rsp_valid a frame passes a bit-serial divider, a sine table read,
// a bit-serial depth multiply, the tap reads and the bit-serial interpolation and mix.
// Throughput: one frame at a time; a stalled result holds off the next.
// Reset: registers take their defaults, then a clearing pass zeroes both delay lines;
// req_stall stays high during it.
module stereo_chorus_delay_mixer #(
   parameter int HISTORY_DEPTH    = scd_pkg::HISTORY_DEPTH_DEF,
   parameter int SAMPLE_BITS      = scd_pkg::SAMPLE_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = scd_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_BITS-1:0]      req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]      req_right_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]      rsp_right_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [scd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [scd_pkg::CSR_DATA_W-1:0]     csr_data
);
   import scd_pkg::*;

   localparam int AW    = $clog2(HISTORY_DEPTH);
   localparam int CB    = $clog2(4 * SINE_TABLE_DEPTH);
   localparam int DB    = $clog2(SINE_TABLE_DEPTH);
   localparam int TAW   = DB + 1;
   localparam int NB    = PERIOD_W + CB;
   localparam int CNT_W = $clog2(NB + 1);
   localparam int PW    = DEPTH_W + SINE_MAG_W;
   localparam int DLW   = BASE_W + 1;
   localparam int DIW   = DLW - FRAC_W;

   localparam logic [3:0] S_CLR = 4'd0,  S_IDLE = 4'd1, S_DIV = 4'd2,  S_ROM = 4'd3;
   localparam logic [3:0] S_MLD = 4'd4,  S_MUL  = 4'd5, S_DLY = 4'd6,  S_RDA = 4'd7;
   localparam logic [3:0] S_RDB = 4'd8,  S_ILD  = 4'd9, S_INT = 4'd10, S_XLD = 4'd11;
   localparam logic [3:0] S_MIX = 4'd12, S_OUT  = 4'd13;

   // Configuration registers
   logic [BASE_W-1:0]   base_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [DW_W-1:0]     drywet_ff;

   logic [3:0]          state_ff, state_in;
   logic [AW-1:0]       clr_ff, wp_ff, ia_ff;
   logic [PERIOD_W-1:0] phase_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [NB-1:0]       num_ff;
   logic [PERIOD_W-1:0] rem_ff;
   logic [CB-1:0]       q_ff;
   logic [SINE_MAG_W-1:0] rom_ff;
   logic                neg_ff;
   logic [DW_W-1:0]     mbits_ff;
   logic [PW-1:0]       pmcand_ff, pacc_ff;
   logic [FRAC_W-1:0]   frac_ff;
   logic signed [SAMPLE_BITS-1:0] dry_l_ff, dry_r_ff, tap_al_ff, tap_ar_ff;
   logic signed [SAMPLE_BITS-1:0] rd_l_ff, rd_r_ff;
   logic                rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_l_ff, out_r_ff;

   logic                accept, out_go;
   logic [PERIOD_W-1:0] period_eff, depth_eff, phase_nx;
   logic [DW_W-1:0]     drywet_eff;
   logic [PERIOD_W:0]   rem_sh;
   logic                qbit;
   logic [TAW-1:0]      rom_addr;
   logic [1:0]          quad;
   logic [DLW-1:0]      delay_q;
   logic [DIW-1:0]      dint;
   logic [FRAC_W-1:0]   frac;
   logic [AW-1:0]       rd_addr, mem_waddr;
   logic                mem_we;
   logic signed [SAMPLE_BITS-1:0] mem_wl, mem_wr, res_l, res_r;
   scd_lane_ctl_type    lane_ctl;

   logic [SINE_MAG_W-1:0] sine_rom [0:SINE_TABLE_DEPTH];
   logic signed [SAMPLE_BITS-1:0] left_mem  [0:HISTORY_DEPTH-1];
   logic signed [SAMPLE_BITS-1:0] right_mem [0:HISTORY_DEPTH-1];

   // Build the quarter-wave table
   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
      localparam longint XQ = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      assign sine_rom[k] = sine_q15_of(XQ);
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign out_go    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_out  = out_l_ff;
   assign rsp_right_out = out_r_ff;

   // Effective register values
   always_comb begin
      period_eff = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
      depth_eff  = (depth_ff < base_ff) ? depth_ff : base_ff;
      drywet_eff = (drywet_ff > DW_ONE) ? DW_ONE : drywet_ff;
      phase_nx   = phase_ff + PERIOD_W'(1);
      if (phase_nx >= period_eff) phase_nx = '0;
   end

   // Restoring divider step
   always_comb begin
      rem_sh = {rem_ff, num_ff[NB-1]};
      qbit   = (rem_sh >= {1'b0, period_eff});
   end

   // Sine table address from quadrant
   always_comb begin
      quad     = q_ff[CB-1 -: 2];
      rom_addr = quad[0] ? TAW'(SINE_TABLE_DEPTH) - {1'b0, q_ff[DB-1:0]}
                         : {1'b0, q_ff[DB-1:0]};
   end

   // Delay from base and modulation, then clamp
   always_comb begin
      if (neg_ff)
         delay_q = {1'b0, base_ff} - DLW'((pacc_ff + PW'(32767)) >> 15);
      else
         delay_q = {1'b0, base_ff} + DLW'(pacc_ff >> 15);
      dint = delay_q[DLW-1:FRAC_W];
      frac = delay_q[FRAC_W-1:0];
      if (32'(dint) >= HISTORY_DEPTH - 1) begin
         dint = DIW'(HISTORY_DEPTH - 2);
         frac = '0;
      end
   end

   // Delay line ports
   always_comb begin
      mem_we    = (state_ff == S_CLR) || accept;
      mem_waddr = (state_ff == S_CLR) ? clr_ff : wp_ff;
      mem_wl    = (state_ff == S_CLR) ? '0 : req_left_in;
      mem_wr    = (state_ff == S_CLR) ? '0 : req_right_in;
      rd_addr   = (state_ff == S_RDB) ? ia_ff - AW'(1) : ia_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         left_mem[mem_waddr]  <= mem_wl;
         right_mem[mem_waddr] <= mem_wr;
      end
      rd_l_ff <= left_mem[rd_addr];
      rd_r_ff <= right_mem[rd_addr];
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLR:  if (clr_ff == AW'(HISTORY_DEPTH - 1)) state_in = S_IDLE;
         S_IDLE: if (accept) state_in = S_DIV;
         S_DIV:  if (cnt_ff == CNT_W'(NB - 1)) state_in = S_ROM;
         S_ROM:  state_in = S_MLD;
         S_MLD:  state_in = S_MUL;
         S_MUL:  if (cnt_ff == CNT_W'(SINE_MAG_W - 1)) state_in = S_DLY;
         S_DLY:  state_in = S_RDA;
         S_RDA:  state_in = S_RDB;
         S_RDB:  state_in = S_ILD;
         S_ILD:  state_in = S_INT;
         S_INT:  if (cnt_ff == CNT_W'(FRAC_W - 1)) state_in = S_XLD;
         S_XLD:  state_in = S_MIX;
         S_MIX:  if (cnt_ff == CNT_W'(DW_W - 1)) state_in = S_OUT;
         S_OUT:  if (out_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= BASE_RST;
         depth_ff     <= DEPTH_RST;
         period_ff    <= PERIOD_RST;
         drywet_ff    <= DW_RST;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLR) clr_ff <= clr_ff + AW'(1);
         if (state_in != state_ff) cnt_ff <= '0;
         else cnt_ff <= cnt_ff + CNT_W'(1);
         if (state_ff == S_OUT && out_go) begin
            rsp_valid_ff <= 1'b1;
            wp_ff        <= wp_ff + AW'(1);
            phase_ff     <= phase_nx;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE:   base_ff   <= csr_data;
               CSR_DEPTH:  depth_ff  <= csr_data;
               CSR_PERIOD: period_ff <= csr_data;
               CSR_DRYWET: drywet_ff <= DW_W'(csr_data);
               default: ;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            dry_l_ff <= req_left_in;
            dry_r_ff <= req_right_in;
            num_ff   <= {phase_ff, {CB{1'b0}}};
            rem_ff   <= '0;
         end
         S_DIV: begin
            rem_ff <= qbit ? PERIOD_W'(rem_sh - {1'b0, period_eff}) : PERIOD_W'(rem_sh);
            q_ff   <= {q_ff[CB-2:0], qbit};
            num_ff <= num_ff << 1;
         end
         S_ROM: begin
            rom_ff <= sine_rom[rom_addr];
            neg_ff <= quad[1];
         end
         S_MLD: begin
            mbits_ff  <= DW_W'(rom_ff);
            pmcand_ff <= PW'(depth_eff);
            pacc_ff   <= '0;
         end
         S_MUL: begin
            if (mbits_ff[0]) pacc_ff <= pacc_ff + pmcand_ff;
            pmcand_ff <= pmcand_ff << 1;
            mbits_ff  <= mbits_ff >> 1;
         end
         S_DLY: begin
            ia_ff   <= wp_ff - AW'(dint);
            frac_ff <= frac;
         end
         S_RDB: begin
            tap_al_ff <= rd_l_ff;
            tap_ar_ff <= rd_r_ff;
         end
         S_ILD: mbits_ff <= DW_W'(frac_ff);
         S_INT: mbits_ff <= mbits_ff >> 1;
         S_XLD: mbits_ff <= drywet_eff;
         S_MIX: mbits_ff <= mbits_ff >> 1;
         S_OUT: begin
            if (out_go) begin
               out_l_ff <= res_l;
               out_r_ff <= res_r;
            end
         end
         default: ;
      endcase
   end

   // Lane controls
   always_comb begin
      lane_ctl.load_interp = (state_ff == S_ILD);
      lane_ctl.load_mix    = (state_ff == S_XLD);
      lane_ctl.step        = (state_ff == S_INT) || (state_ff == S_MIX);
      lane_ctl.mbit        = mbits_ff[0];
   end

   scd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_l (
      .clock  (clock),
      .ctl    (lane_ctl),
      .dry    (dry_l_ff),
      .tap_a  (tap_al_ff),
      .tap_b  (rd_l_ff),
      .result (res_l)
   );

   scd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_r (
      .clock  (clock),
      .ctl    (lane_ctl),
      .dry    (dry_r_ff),
      .tap_a  (tap_ar_ff),
      .tap_b  (rd_r_ff),
      .result (res_r)
   );

endmodule

>>> test/tb_stereo_chorus_delay_mixer.sv
// Self-checking testbench for the stereo chorus delay mixer, with a built-in chorus predictor.
module tb_stereo_chorus_delay_mixer;
   timeunit 1ns;
   timeprecision 1ps;
   import scd_pkg::*;

   localparam int DEPTH = 4096;
   localparam int SINE_N = 1024;
   localparam longint QUARTER_Q30 = 64'sd1686629713;
   localparam int SETTLE = 120;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } frame_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_left_in = '0;
   logic signed [15:0] req_right_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_left_out;
   logic signed [15:0] rsp_right_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BASE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor state and registers
   logic signed [15:0] left_line [DEPTH];
   logic signed [15:0] right_line [DEPTH];
   logic [11:0] wr_pos;
   logic [19:0] phase;
   logic [19:0] base_q8, depth_q8, period_r;
   logic [16:0] wet_mix;
   longint sine_q15 [SINE_N+1];

   frame_t chorus_q[$];
   int errors = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int long_hold = 0;

   stereo_chorus_delay_mixer dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   // Quarter-wave sine in Q15 from a Taylor series in Q30
   function automatic longint taylor_sine(int k);
      longint x, x2, term, sum, n;
      x = longint'((64'(k) * 64'(QUARTER_Q30)) / 64'(SINE_N));
      x2 = (x * x) >>> 30;
      term = x;
      sum = x;
      n = 1;
      for (int i = 0; i < 5; i++) begin
         term = ((term * x2) >>> 30) / ((n + 1) * (n + 2));
         n += 2;
         if (i % 2 == 1) sum += term;
         else sum -= term;
      end
      if (sum < 0) sum = 0;
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 32768) sum = 32768;
      return sum;
   endfunction

   function automatic logic signed [15:0] mix_sat(longint dry, longint wet8, longint w);
      longint acc, v;
      acc = dry * (131072 - w) * 256 + wet8 * w;
      v = (acc + 64'sd16777216) >>> 25;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   // Write the frame, read the modulated taps, mix, then advance pointer and lfo
   function automatic frame_t chorus_frame(logic signed [15:0] l, logic signed [15:0] r);
      longint per, dep, w, idx, s, dly, fr, lc, rc;
      int dint, ia, ib;
      frame_t f;
      per = (period_r == 0) ? 1 : longint'(period_r);
      dep = (depth_q8 < base_q8) ? longint'(depth_q8) : longint'(base_q8);
      w = (wet_mix > DW_ONE) ? 65536 : longint'(wet_mix);
      idx = ((longint'(phase) * 4 * SINE_N) / per) % (4 * SINE_N);
      case (idx / SINE_N)
         0: s = sine_q15[idx % SINE_N];
         1: s = sine_q15[SINE_N - idx % SINE_N];
         2: s = -sine_q15[idx % SINE_N];
         default: s = -sine_q15[SINE_N - idx % SINE_N];
      endcase
      dly = longint'(base_q8) + ((dep * s) >>> 15);
      dint = int'(dly >>> 8);
      fr = dly & 255;
      if (dint >= DEPTH - 1) begin
         dint = DEPTH - 2;
         fr = 0;
      end
      left_line[wr_pos] = l;
      right_line[wr_pos] = r;
      ia = (int'(wr_pos) + DEPTH - dint) % DEPTH;
      ib = (ia + DEPTH - 1) % DEPTH;
      lc = longint'(left_line[ia]) * (256 - fr) + longint'(left_line[ib]) * fr;
      rc = longint'(right_line[ia]) * (256 - fr) + longint'(right_line[ib]) * fr;
      f.left = mix_sat(l, lc, w);
      f.right = mix_sat(r, rc, w);
      wr_pos = wr_pos + 1'b1;
      phase = phase + 1'b1;
      if (longint'(phase) >= per) phase = '0;
      return f;
   endfunction

   // Compare each result transfer against the oldest expectation
   always @(posedge clock) begin
      frame_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (chorus_q.size() == 0) begin
            $error("unexpected result transfer: left %0d right %0d", rsp_left_out,
                   rsp_right_out);
            errors++;
         end else begin
            want = chorus_q.pop_front();
            if (rsp_left_out !== want.left) begin
               $error("left_out: expected %0d, got %0d", want.left, rsp_left_out);
               errors++;
            end
            if (rsp_right_out !== want.right) begin
               $error("right_out: expected %0d, got %0d", want.right, rsp_right_out);
               errors++;
            end
         end
      end
   end

   // Receiver stall: random, or held for a long stretch on request
   always @(negedge clock) begin
      if (long_hold > 0) begin
         rsp_stall <= 1'b1;
         long_hold--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offer one frame after random idle cycles; called and returns at a falling edge
   task automatic send_frame(logic signed [15:0] l, logic signed [15:0] r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_left_in = l;
      req_right_in = r;
      do @(posedge clock); while (req_stall);
      chorus_q.push_back(chorus_frame(l, r));
      @(negedge clock);
   endtask

   // Wait for all results, then let the block settle so it is idle
   task automatic drain();
      req_valid = 1'b0;
      wait (chorus_q.size() == 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [19:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BASE: base_q8 = value;
         CSR_DEPTH: depth_q8 = value;
         CSR_PERIOD: period_r = value;
         default: wet_mix = value[16:0];
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_all(logic [19:0] b, logic [19:0] d, logic [19:0] p, logic [19:0] w);
      drain();
      csr_write(CSR_BASE, b);
      csr_write(CSR_DEPTH, d);
      csr_write(CSR_PERIOD, p);
      csr_write(CSR_DRYWET, w);
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [19:0] rand_reg(logic [19:0] top);
      case ($urandom_range(5))
         0: return '0;
         1: return top;
         2: return 20'($urandom_range(0, 4096));
         default: return 20'($urandom_range(0, top));
      endcase
   endfunction

   // Extremes of the samples at reset settings, then each corner of the delay path
   task automatic test_directed();
      send_frame(16'sh7FFF, 16'sh8000);
      send_frame(16'sh8000, 16'sh7FFF);
      send_frame(16'sh0000, 16'shFFFF);
      // zero delay at the top wet setting gives back the current input
      set_all(20'd0, 20'd0, 20'd100, 20'd65536);
      send_frame(16'sh7FFF, 16'sh8000);
      send_frame(16'sh1234, -16'sh1234);
      // long delay clamps to the oldest usable tap
      set_all(20'hFFFFF, 20'd0, 20'd50, 20'd65536);
      send_frame(16'sh4000, 16'shC000);
      send_frame(16'sh7FFF, 16'sh8000);
      // depth over base, zero period, wet over one
      set_all(20'd256, 20'hFFFFF, 20'd0, 20'h1FFFF);
      send_frame(16'sh7FFF, 16'sh8000);
      send_frame(16'sh0001, 16'shFFFF);
      set_all(20'd0, 20'd0, 20'd1, 20'd0);
      send_frame(16'sh7FFF, 16'sh8000);
      // lower the period below the running phase
      set_all(20'd2560, 20'd2560, 20'd20, 20'd32768);
      repeat (8) send_frame(rand_sample(), rand_sample());
      drain();
      csr_write(CSR_PERIOD, 20'd3);
      repeat (3) send_frame(rand_sample(), rand_sample());
   endtask

   // Random settings per block of frames under one idling profile
   task automatic test_random(int idle, int stall, int frames);
      drain();
      idle_pct = idle;
      stall_pct = stall;
      for (int blk = 0; blk < 3; blk++) begin
         set_all(rand_reg(20'hFFFFF), rand_reg(20'hFFFFF), rand_reg(20'hFFFFF),
                 20'($urandom_range(0, 131071)));
         repeat (frames) send_frame(rand_sample(), rand_sample());
      end
   endtask

   // Hold off the receiver while frames keep coming, pause until all are back, then send more
   task automatic test_backpressure();
      set_all(20'd100000, 20'd30000, 20'd64, 20'd40000);
      idle_pct = 0;
      stall_pct = 0;
      @(posedge clock);
      long_hold = 600;
      @(negedge clock);
      repeat (30) send_frame(rand_sample(), rand_sample());
      drain();
      repeat (20) send_frame(rand_sample(), rand_sample());
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         left_line[i] = '0;
         right_line[i] = '0;
      end
      for (int k = 0; k <= SINE_N; k++) sine_q15[k] = taylor_sine(k);
      wr_pos = '0;
      phase = '0;
      base_q8 = BASE_RST;
      depth_q8 = DEPTH_RST;
      period_r = PERIOD_RST;
      wet_mix = DW_RST;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_backpressure();
      test_random(0, 0, 100);
      test_random(67, 0, 100);
      test_random(0, 67, 100);
      test_random(16, 16, 100);
      drain();
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
